[sv/sha1_sha256_hash_engine_defines.svh]
// Assertion helpers used by the hash engine RTL
`ifndef SHA1_SHA256_HASH_ENGINE_DEFINES_SVH
`define SHA1_SHA256_HASH_ENGINE_DEFINES_SVH

// Same-cycle implication, ignored during reset
`define SHA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hash engine assertion failed");

// Next-cycle implication, ignored during reset
`define SHA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hash engine assertion failed");

`endif

[sv/sha_pkg.sv]
`timescale 1ns / 1ps
package sha_pkg;
   typedef logic [7:0][31:0]  hash_state_type;
   typedef logic [15:0][31:0] sched_window_type;

   localparam logic [1:0] OP_RESTART = 2'd0;
   localparam logic [1:0] OP_PUSH    = 2'd1;
   localparam logic [1:0] OP_FINISH  = 2'd2;

   localparam logic [6:0] ROUNDS_SHA256 = 7'd64;
   localparam logic [6:0] ROUNDS_SHA1   = 7'd80;

   localparam logic [31:0] PAD_MARKER = 32'h8000_0000;

   localparam logic [31:0] K1 [4] = '{32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6};

   localparam logic [31:0] K256 [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam hash_state_type IV256 = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

   localparam hash_state_type IV1 = {
      32'h0, 32'h0, 32'h0, 32'hC3D2E1F0,
      32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301};

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction
endpackage

[sv/sha1_sha256_hash_engine.sv]
`timescale 1ns / 1ps
// Channel   | Ports                                         | Direction
// request   | req_valid/req_ready, req_opcode, req_message_word | in
// response  | rsp_valid/rsp_ready, rsp_digest_word/index/last   | out
// csr       | csr_write_enable, csr_write_data              | in
//
// Restart and a non-final push stay in idle. The 16th push runs one compression:
// a load, 64 (SHA-256) or 80 (SHA-1) rounds on the shared round unit, and an add.
// Finish runs one or two compressions, then shows 8 or 5 digest words, one per
// accepted response. Synchronous reset loads the SHA-256 initial values.
// A stalled response holds the engine until the word is taken.
module sha1_sha256_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_message_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_digest_index,
   output logic        rsp_digest_last,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);
   import sha_pkg::*;
   `include "sha1_sha256_hash_engine_defines.svh"

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_ROUND = 3'd2;
   localparam logic [2:0] ST_ADD   = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic             sha1_ff, sha1_in;
   hash_state_type   hash_ff, hash_in;
   hash_state_type   v_ff, v_in, v_next;
   sched_window_type buf_ff, buf_in;
   sched_window_type win_ff, win_in;
   logic [3:0]       fill_ff, fill_in;
   logic [31:0]      count_ff, count_in;
   logic [31:0]      len_ff, len_in;
   logic             second_ff, second_in;
   logic             finish_ff, finish_in;
   logic [6:0]       round_ff, round_in;
   logic [2:0]       idx_ff, idx_in;
   logic [31:0]      w;
   logic             req_fire, rsp_fire, last_round;

   sha_round u_round (
      .sha1   (sha1_ff),
      .round  (round_ff),
      .v      (v_ff),
      .window (win_ff),
      .v_next (v_next),
      .w      (w)
   );

   assign req_ready        = (state_ff == ST_IDLE);
   assign req_fire         = req_valid && req_ready;
   assign rsp_valid        = (state_ff == ST_EMIT);
   assign rsp_fire         = rsp_valid && rsp_ready;
   assign rsp_digest_word  = hash_ff[idx_ff];
   assign rsp_digest_index = idx_ff;
   assign rsp_digest_last  = sha1_ff ? (idx_ff == 3'd4) : (idx_ff == 3'd7);
   assign last_round       = sha1_ff ? (round_ff == ROUNDS_SHA1 - 7'd1)
                                     : (round_ff == ROUNDS_SHA256 - 7'd1);

   always_comb begin
      state_in  = state_ff;
      sha1_in   = csr_write_enable ? csr_write_data : sha1_ff;
      hash_in   = hash_ff;
      v_in      = v_ff;
      buf_in    = buf_ff;
      win_in    = win_ff;
      fill_in   = fill_ff;
      count_in  = count_ff;
      len_in    = len_ff;
      second_in = second_ff;
      finish_in = finish_ff;
      round_in  = round_ff;
      idx_in    = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_opcode)
                  OP_RESTART: begin
                     hash_in  = sha1_ff ? IV1 : IV256;
                     count_in = 32'd0;
                     fill_in  = 4'd0;
                  end
                  OP_PUSH: begin
                     buf_in[fill_ff] = {req_message_word[7:0], req_message_word[15:8],
                                        req_message_word[23:16], req_message_word[31:24]};
                     count_in = count_ff + 32'd1;
                     fill_in  = fill_ff + 4'd1;
                     if (fill_ff == 4'd15) begin
                        state_in = ST_LOAD;
                     end
                  end
                  OP_FINISH: begin
                     for (int i = 0; i < 16; i++) begin
                        if (4'(i) > fill_ff) begin
                           buf_in[i] = 32'd0;
                        end
                     end
                     buf_in[fill_ff] = PAD_MARKER;
                     // room for the length only when fewer than 14 words are buffered
                     if (fill_ff < 4'd14) begin
                        buf_in[15] = {count_ff[26:0], 5'd0};
                     end
                     second_in = (fill_ff >= 4'd14);
                     len_in    = {count_ff[26:0], 5'd0};
                     finish_in = 1'b1;
                     fill_in   = 4'd0;
                     state_in  = ST_LOAD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOAD: begin
            win_in   = buf_ff;
            v_in     = hash_ff;
            round_in = 7'd0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            v_in     = v_next;
            win_in   = {w, win_ff[15:1]};
            round_in = round_ff + 7'd1;
            if (last_round) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++) begin
               if (!sha1_ff || i < 5) begin
                  hash_in[i] = hash_ff[i] + v_ff[i];
               end
            end
            if (second_ff) begin
               buf_in     = '0;
               buf_in[15] = len_ff;
               second_in  = 1'b0;
               state_in   = ST_LOAD;
            end else if (finish_ff) begin
               idx_in   = 3'd0;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               if (rsp_digest_last) begin
                  finish_in = 1'b0;
                  state_in  = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         sha1_ff   <= 1'b0;
         hash_ff   <= IV256;
         fill_ff   <= 4'd0;
         count_ff  <= 32'd0;
         second_ff <= 1'b0;
         finish_ff <= 1'b0;
         round_ff  <= 7'd0;
         idx_ff    <= 3'd0;
      end else begin
         state_ff  <= state_in;
         sha1_ff   <= sha1_in;
         hash_ff   <= hash_in;
         fill_ff   <= fill_in;
         count_ff  <= count_in;
         second_ff <= second_in;
         finish_ff <= finish_in;
         round_ff  <= round_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      buf_ff <= buf_in;
      win_ff <= win_in;
      len_ff <= len_in;
   end

   `SHA_ASSERT_NEXT(a_load_to_round, state_ff == ST_LOAD, state_ff == ST_ROUND && round_ff == 7'd0)
   `SHA_ASSERT_NOW(a_round_bound, state_ff == ST_ROUND, round_ff < ROUNDS_SHA1)
   `SHA_ASSERT_NOW(a_emit_only_finish, rsp_valid, finish_ff && !second_ff)
   `SHA_ASSERT_NOW(a_emit_index, rsp_valid && sha1_ff, idx_ff <= 3'd4)
   `SHA_ASSERT_NEXT(a_push_full, req_fire && req_opcode == OP_PUSH && fill_ff == 4'd15,
                    state_ff == ST_LOAD && fill_ff == 4'd0)
endmodule

[sv/sha_round.sv]
`timescale 1ns / 1ps
module sha_round (
   input  logic                      sha1,
   input  logic [6:0]                round,
   input  sha_pkg::hash_state_type   v,
   input  sha_pkg::sched_window_type window,
   output sha_pkg::hash_state_type   v_next,
   output logic [31:0]               w
);
   import sha_pkg::*;

   logic [31:0] m0, m1, s0w, s1w, x1, a, e;
   logic [31:0] s1, ch, t1, s0, mj, f, t, k1;

   // from round 16 on, window[0] is W[r-16] and window[15] is W[r-1]
   always_comb begin
      m0  = window[1];
      m1  = window[14];
      s0w = rotr(m0, 7) ^ rotr(m0, 18) ^ (m0 >> 3);
      s1w = rotr(m1, 17) ^ rotr(m1, 19) ^ (m1 >> 10);
      x1  = window[13] ^ window[8] ^ window[2] ^ window[0];
      if (round < 7'd16) begin
         w = window[0];
      end else if (sha1) begin
         w = rotr(x1, 31);
      end else begin
         w = window[0] + window[9] + s0w + s1w;
      end

      a  = v[0];
      e  = v[4];
      s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
      ch = (e & v[5]) ^ (~e & v[6]);
      t1 = v[7] + s1 + ch + K256[round[5:0]] + w;
      s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
      mj = (a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]);

      if (round < 7'd20) begin
         f  = (v[1] & v[2]) | (~v[1] & v[3]);
         k1 = K1[0];
      end else if (round < 7'd40) begin
         f  = v[1] ^ v[2] ^ v[3];
         k1 = K1[1];
      end else if (round < 7'd60) begin
         f  = (v[1] & v[2]) | (v[1] & v[3]) | (v[2] & v[3]);
         k1 = K1[2];
      end else begin
         f  = v[1] ^ v[2] ^ v[3];
         k1 = K1[3];
      end
      t = rotr(a, 27) + f + v[4] + k1 + w;

      v_next = v;
      if (sha1) begin
         v_next[4] = v[3];
         v_next[3] = v[2];
         v_next[2] = rotr(v[1], 2);
         v_next[1] = a;
         v_next[0] = t;
      end else begin
         v_next[7] = v[6];
         v_next[6] = v[5];
         v_next[5] = e;
         v_next[4] = v[3] + t1;
         v_next[3] = v[2];
         v_next[2] = v[1];
         v_next[1] = a;
         v_next[0] = t1 + s0 + mj;
      end
   end
endmodule
